>>> design/rv32d_pkg.sv
// Package for the RV32 instruction decoder: opcodes, control flag positions,
// stall counts and the decoded result type. Depends on nothing.
`default_nettype none

package rv32d_pkg;

    localparam int unsigned INSTR_W  = 32;
    localparam int unsigned OPCODE_W = 7;
    localparam int unsigned REG_W    = 5;
    localparam int unsigned FUNCT3_W = 3;
    localparam int unsigned FUNCT7_W = 7;
    localparam int unsigned FLAGS_W  = 12;
    localparam int unsigned STALL_W  = 3;

    // Major opcodes
    localparam logic [OPCODE_W-1:0] OP_RTYPE  = 7'b0110011;
    localparam logic [OPCODE_W-1:0] OP_ITYPE  = 7'b0010011;
    localparam logic [OPCODE_W-1:0] OP_JALR   = 7'b1100111;
    localparam logic [OPCODE_W-1:0] OP_BRANCH = 7'b1100011;
    localparam logic [OPCODE_W-1:0] OP_LOAD   = 7'b0000011;
    localparam logic [OPCODE_W-1:0] OP_FLOAD  = 7'b0000111;
    localparam logic [OPCODE_W-1:0] OP_STORE  = 7'b0100011;
    localparam logic [OPCODE_W-1:0] OP_FSTORE = 7'b0100111;
    localparam logic [OPCODE_W-1:0] OP_LUI    = 7'b0110111;
    localparam logic [OPCODE_W-1:0] OP_AUIPC  = 7'b0010111;
    localparam logic [OPCODE_W-1:0] OP_JAL    = 7'b1101111;
    localparam logic [OPCODE_W-1:0] OP_FPALU  = 7'b1010011;

    // funct7 codes that select the inverted operation
    localparam logic [FUNCT7_W-1:0] F7_INT_INVERT = 7'd32;
    localparam logic [FUNCT7_W-1:0] F7_FP_INVERT  = 7'd4;

    // Control flag bit positions
    localparam int unsigned FL_BRANCH   = 0;
    localparam int unsigned FL_MEMREAD  = 1;
    localparam int unsigned FL_MEM2REG  = 2;
    localparam int unsigned FL_MEMWRITE = 3;
    localparam int unsigned FL_ALUSRC   = 4;
    localparam int unsigned FL_REGWRITE = 5;
    localparam int unsigned FL_RS1SRC   = 6;
    localparam int unsigned FL_PCWRITE  = 7;
    localparam int unsigned FL_INVERT   = 8;
    localparam int unsigned FL_FLOATREG = 9;
    localparam int unsigned FL_FOP      = 10;
    localparam int unsigned FL_LUI      = 11;

    // Stall counts
    localparam logic [STALL_W-1:0] STALL_NONE = 3'd0;
    localparam logic [STALL_W-1:0] STALL_MEM  = 3'd2;
    localparam logic [STALL_W-1:0] STALL_FP   = 3'd5;

    typedef struct packed {
        logic [OPCODE_W-1:0] opcode_bits;
        logic [REG_W-1:0]    dest_reg;
        logic [REG_W-1:0]    src1_reg;
        logic [REG_W-1:0]    src2_reg;
        logic [FUNCT7_W-1:0] funct7_bits;
        logic [FUNCT3_W-1:0] alu_operation;
        logic [INSTR_W-1:0]  immediate;
        logic [FLAGS_W-1:0]  control_flags;
        logic [STALL_W-1:0]  stall_cycles;
    } decode_t;

endpackage

`default_nettype wire

>>> design/rv32d_decode.sv
// Combinational decode of one RV32 instruction word into fields, immediate,
// control flags and stall count. Depends on rv32d_pkg.
`default_nettype none

module rv32d_decode (
    input  wire logic [rv32d_pkg::INSTR_W-1:0] instr,
    output rv32d_pkg::decode_t                 dec
);
    import rv32d_pkg::*;

    logic [OPCODE_W-1:0] op;
    logic [FUNCT3_W-1:0] f3;
    logic [FUNCT7_W-1:0] f7;
    logic [INSTR_W-1:0]  imm_i;
    logic [INSTR_W-1:0]  imm_s;
    logic [INSTR_W-1:0]  imm_b;
    logic [INSTR_W-1:0]  imm_u;
    logic [INSTR_W-1:0]  imm_j;
    logic [FUNCT3_W-1:0] aluop;
    logic [INSTR_W-1:0]  imm;
    logic [FLAGS_W-1:0]  flags;
    logic [STALL_W-1:0]  stall;

    assign op = instr[6:0];
    assign f3 = instr[14:12];
    assign f7 = instr[31:25];

    // I, S, U and J stay zero-extended; only B carries its sign
    assign imm_i = {20'd0, instr[31:20]};
    assign imm_s = {20'd0, instr[31:25], instr[11:7]};
    assign imm_b = {{19{instr[31]}}, instr[31], instr[7], instr[30:25], instr[11:8], 1'b0};
    assign imm_u = {12'd0, instr[31:12]};
    assign imm_j = {11'd0, instr[31], instr[19:12], instr[20], instr[30:21], 1'b0};

    always_comb
    begin
        aluop = '0;
        imm   = '0;
        flags = '0;
        stall = STALL_NONE;
        unique case (op)
            OP_RTYPE:
            begin
                aluop                 = f3;
                flags[FL_REGWRITE]    = 1'b1;
                flags[FL_INVERT]      = (f7 == F7_INT_INVERT);
            end
            OP_ITYPE:
            begin
                aluop                 = f3;
                flags[FL_ALUSRC]      = 1'b1;
                flags[FL_REGWRITE]    = 1'b1;
                imm                   = imm_i;
            end
            OP_JALR:
            begin
                flags[FL_BRANCH]      = 1'b1;
                flags[FL_ALUSRC]      = 1'b1;
                flags[FL_REGWRITE]    = 1'b1;
                flags[FL_RS1SRC]      = 1'b1;
                flags[FL_PCWRITE]     = 1'b1;
                imm                   = imm_i;
            end
            OP_BRANCH:
            begin
                flags[FL_BRANCH]      = 1'b1;
                imm                   = imm_b;
            end
            OP_LOAD, OP_FLOAD:
            begin
                flags[FL_MEMREAD]     = 1'b1;
                flags[FL_MEM2REG]     = 1'b1;
                flags[FL_ALUSRC]      = 1'b1;
                flags[FL_REGWRITE]    = 1'b1;
                flags[FL_FLOATREG]    = (op == OP_FLOAD);
                imm                   = imm_i;
                stall                 = STALL_MEM;
            end
            OP_STORE, OP_FSTORE:
            begin
                flags[FL_MEMWRITE]    = 1'b1;
                flags[FL_ALUSRC]      = 1'b1;
                flags[FL_FLOATREG]    = (op == OP_FSTORE);
                imm                   = imm_s;
                stall                 = STALL_MEM;
            end
            OP_LUI:
            begin
                flags[FL_ALUSRC]      = 1'b1;
                flags[FL_REGWRITE]    = 1'b1;
                flags[FL_LUI]         = 1'b1;
                imm                   = imm_u;
            end
            OP_AUIPC:
            begin
                flags[FL_ALUSRC]      = 1'b1;
                flags[FL_REGWRITE]    = 1'b1;
                flags[FL_RS1SRC]      = 1'b1;
                imm                   = imm_u;
            end
            OP_JAL:
            begin
                flags[FL_BRANCH]      = 1'b1;
                flags[FL_ALUSRC]      = 1'b1;
                flags[FL_REGWRITE]    = 1'b1;
                flags[FL_RS1SRC]      = 1'b1;
                flags[FL_PCWRITE]     = 1'b1;
                imm                   = imm_j;
            end
            OP_FPALU:
            begin
                aluop                 = f3;
                flags[FL_REGWRITE]    = 1'b1;
                flags[FL_FOP]         = 1'b1;
                flags[FL_INVERT]      = (f7 == F7_FP_INVERT);
                stall                 = STALL_FP;
            end
            default:
            begin
                // unknown opcode: leave all controls and the immediate at zero
            end
        endcase
    end

    assign dec.opcode_bits   = op;
    assign dec.dest_reg      = instr[11:7];
    assign dec.src1_reg      = instr[19:15];
    assign dec.src2_reg      = instr[24:20];
    assign dec.funct7_bits   = f7;
    assign dec.alu_operation = aluop;
    assign dec.immediate     = imm;
    assign dec.control_flags = flags;
    assign dec.stall_cycles  = stall;

endmodule

`default_nettype wire

>>> design/rv32_instruction_decoder_top.sv
// Top level of the RV32 instruction decoder: input register, decode logic,
// result register. Depends on rv32d_pkg and rv32d_decode.
//
//   channel   | ports                                  | transaction taken when
//   ----------+----------------------------------------+------------------------
//   command   | start, busy, instr_word                | start && !busy
//   result    | done, opcode_bits .. stall_cycles      | done (one cycle, no stall)
//
// Cycles: one instruction per clock; each command passes the input register,
// then the result register. Throughput is set by the single decode pass
// between those two registers.
// busy is always low: every stage advances every cycle.
// Reset: rst_n clears the valid bits of both stages; payload is not reset.
// Stalls: the receiver cannot hold results off, so nothing ever stalls.
`default_nettype none

module rv32_instruction_decoder_top (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           start,
    output logic                                busy,
    input  wire logic [rv32d_pkg::INSTR_W-1:0]  instr_word,
    output logic                                done,
    output logic [rv32d_pkg::OPCODE_W-1:0]      opcode_bits,
    output logic [rv32d_pkg::REG_W-1:0]         dest_reg,
    output logic [rv32d_pkg::REG_W-1:0]         src1_reg,
    output logic [rv32d_pkg::REG_W-1:0]         src2_reg,
    output logic [rv32d_pkg::FUNCT7_W-1:0]      funct7_bits,
    output logic [rv32d_pkg::FUNCT3_W-1:0]      alu_operation,
    output logic [rv32d_pkg::INSTR_W-1:0]       immediate,
    output logic [rv32d_pkg::FLAGS_W-1:0]       control_flags,
    output logic [rv32d_pkg::STALL_W-1:0]       stall_cycles
);
    import rv32d_pkg::*;

    // Input stage
    logic               in_valid_reg;
    logic [INSTR_W-1:0] instr_reg;

    // Result stage
    logic               out_valid_reg;
    decode_t            result_reg;
    decode_t            result_next;

    // The decode pass is combinational, so the block never holds off a command
    assign busy = 1'b0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= start && !busy;
            out_valid_reg <= in_valid_reg;
        end
    end

    // Capture the instruction word on every accepted command
    always_ff @(posedge clk)
    begin
        if (start && !busy)
        begin
            instr_reg <= instr_word;
        end
    end

    rv32d_decode u_decode (
        .instr (instr_reg),
        .dec   (result_next)
    );

    // Load the result register whenever the input stage holds a transaction
    always_ff @(posedge clk)
    begin
        if (in_valid_reg)
        begin
            result_reg <= result_next;
        end
    end

    assign done          = out_valid_reg;
    assign opcode_bits   = result_reg.opcode_bits;
    assign dest_reg      = result_reg.dest_reg;
    assign src1_reg      = result_reg.src1_reg;
    assign src2_reg      = result_reg.src2_reg;
    assign funct7_bits   = result_reg.funct7_bits;
    assign alu_operation = result_reg.alu_operation;
    assign immediate     = result_reg.immediate;
    assign control_flags = result_reg.control_flags;
    assign stall_cycles  = result_reg.stall_cycles;

    // Every accepted command yields exactly one result, via the input and result registers
    a_cmd_to_result: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##2 done)
        else $error("accepted command produced no result");

    // A result strobe always traces back to a command
    a_result_has_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(in_valid_reg))
        else $error("result strobe without a command");

    // FP ALU stall goes only with the FP operation flag
    a_fp_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (done && stall_cycles == STALL_FP) |-> control_flags[FL_FOP])
        else $error("FP stall without FP operation flag");

    // Memory stall goes only with a memory read or write
    a_mem_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (done && stall_cycles == STALL_MEM) |->
            (control_flags[FL_MEMREAD] || control_flags[FL_MEMWRITE]))
        else $error("memory stall without memory access");

    // Upper immediate flag only for LUI
    a_lui_flag: assert property (@(posedge clk) disable iff (!rst_n)
        (done && control_flags[FL_LUI]) |-> (opcode_bits == OP_LUI))
        else $error("lui flag on a non-LUI opcode");

endmodule

`default_nettype wire
